[hw/rtl/ssi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared constants and helpers for the segment / sphere intersection pipeline.
// ----------------------------------------------------------------------------
package ssi_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;

	// configuration register indexes
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 4'd3;

	// multiplier digit per cell
	localparam int MUL_DIG = 16;

	// quotient bits produced by the divider row, clamp at 2**CLAMP_EXP
	localparam int QUOT_BITS = 63;
	localparam int CLAMP_EXP = 62;
	localparam int DIV_LAT   = QUOT_BITS + 2;

	// width of the point sum before saturation
	localparam int SUM_W = 66;

	function automatic int mul_lat(input int wb);
		return (wb + MUL_DIG - 1) / MUL_DIG;
	endfunction

endpackage

[hw/rtl/segment_sphere_intersection.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_sphere_intersection
// Tests a segment against the configured sphere with exact wide integer math
// and returns up to two rounded, saturated hit points on the segment.
//
// channel   direction  beat contents
// cfg       in         cfg_index, cfg_data (register write)
// in        in         start_x/y/z, end_x/y/z
// out       out        hit_count, first_x/y/z, second_x/y/z, degenerate
//
// one segment per cycle while the output is not stalled; L1 and L2 are the
// multiplier rows.
// the square root row (one bit per cell) and the divider row set the depth.
// reset sets the center to zero and the radius to one; no clearing pass.
// a result held at the output stalls the whole pipeline until it is taken.
// ----------------------------------------------------------------------------
module segment_sphere_intersection #(
	parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH,
	parameter int FRAC_BITS   = ssi_pkg::FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ssi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [COORD_WIDTH-1:0]            cfg_data,

	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [COORD_WIDTH-1:0]     start_x,
	input  logic signed [COORD_WIDTH-1:0]     start_y,
	input  logic signed [COORD_WIDTH-1:0]     start_z,
	input  logic signed [COORD_WIDTH-1:0]     end_x,
	input  logic signed [COORD_WIDTH-1:0]     end_y,
	input  logic signed [COORD_WIDTH-1:0]     end_z,

	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        hit_count,
	output logic signed [COORD_WIDTH-1:0]     first_x,
	output logic signed [COORD_WIDTH-1:0]     first_y,
	output logic signed [COORD_WIDTH-1:0]     first_z,
	output logic signed [COORD_WIDTH-1:0]     second_x,
	output logic signed [COORD_WIDTH-1:0]     second_y,
	output logic signed [COORD_WIDTH-1:0]     second_z,
	output logic                              degenerate
);

	localparam int CW   = COORD_WIDTH;
	localparam int DW   = CW + 1;
	localparam int PW   = 2 * DW;
	localparam int AW   = 2 * CW + 2;
	localparam int HW   = 2 * CW + 3;
	localparam int MAGW = HW - 1;
	localparam int UDW  = 4 * CW + 4;
	localparam int QW   = UDW + 1;
	localparam int RW   = UDW / 2;
	localparam int MW   = 2 * CW + 4;
	localparam int MMW  = MW - 1;
	localparam int NW   = CW + MMW;
	localparam int RRW  = 2 * (CW - 1);
	localparam int QB   = ssi_pkg::QUOT_BITS;
	localparam int SW   = ssi_pkg::SUM_W;
	localparam int L1   = ssi_pkg::mul_lat(MAGW);
	localparam int L2   = ssi_pkg::mul_lat(MMW);
	localparam int DL   = ssi_pkg::DIV_LAT;
	localparam int TOT  = 7 + L1 + RW + L2 + DL;
	localparam int N_DM = 4 + L1 + RW;
	localparam int N_SB = N_DM + L2 + DL;
	localparam int SBW  = 6 * CW + 4;
	localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

	// configuration
	logic signed [CW-1:0] ctr_q [3];
	logic [CW-2:0]        radius_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q[0] <= '0;
			ctr_q[1] <= '0;
			ctr_q[2] <= '0;
			radius_q <= (CW-1)'(1) << FRAC_BITS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ssi_pkg::REG_CENTER_X: ctr_q[0] <= cfg_data;
				ssi_pkg::REG_CENTER_Y: ctr_q[1] <= cfg_data;
				ssi_pkg::REG_CENTER_Z: ctr_q[2] <= cfg_data;
				ssi_pkg::REG_RADIUS:   radius_q <= cfg_data[CW-2:0];
				default: ;
			endcase
		end
	end

	// pipeline control
	logic [TOT-1:0] vld_q;
	logic           en;

	assign en        = !vld_q[TOT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[TOT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOT-2:0], in_valid};
		end
	end

	// stage 1: differences
	logic signed [CW-1:0] s_in [3];
	logic signed [CW-1:0] e_in [3];
	logic signed [CW-1:0] s_s1 [3];
	logic signed [CW-1:0] e_s1 [3];
	logic signed [DW-1:0] d_s1 [3];
	logic signed [DW-1:0] f_s1 [3];

	assign s_in[0] = start_x;
	assign s_in[1] = start_y;
	assign s_in[2] = start_z;
	assign e_in[0] = end_x;
	assign e_in[1] = end_y;
	assign e_in[2] = end_z;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				s_s1[i] <= s_in[i];
				e_s1[i] <= e_in[i];
				d_s1[i] <= {e_in[i][CW-1], e_in[i]} - {s_in[i][CW-1], s_in[i]};
				f_s1[i] <= {s_in[i][CW-1], s_in[i]} - {ctr_q[i][CW-1], ctr_q[i]};
			end
		end
	end

	logic [SBW-1:0]  sb_w;
	logic [3*CW-1:0] dm_w;

	always_comb begin
		logic [DW-1:0] dabs;
		sb_w    = '0;
		dm_w    = '0;
		sb_w[0] = (d_s1[0] == '0) && (d_s1[1] == '0) && (d_s1[2] == '0);
		for (int i = 0; i < 3; i++) begin
			dabs = d_s1[i][DW-1] ? -d_s1[i] : d_s1[i];
			sb_w[1+i]                = d_s1[i][DW-1];
			sb_w[4+i*CW +: CW]       = s_s1[i];
			sb_w[4+(3+i)*CW +: CW]   = e_s1[i];
			dm_w[i*CW +: CW]         = dabs[CW-1:0];
		end
	end

	// stage 2: products
	logic signed [PW-1:0] dd_s2 [3];
	logic signed [PW-1:0] df_s2 [3];
	logic signed [PW-1:0] ff_s2 [3];
	logic [RRW-1:0]       rr_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dd_s2[i] <= d_s1[i] * d_s1[i];
				df_s2[i] <= d_s1[i] * f_s1[i];
				ff_s2[i] <= f_s1[i] * f_s1[i];
			end
			rr_s2 <= RRW'(radius_q) * RRW'(radius_q);
		end
	end

	// stage 3: quadratic coefficients
	logic [AW-1:0]        a_s3;
	logic signed [HW-1:0] h_s3;
	logic signed [HW-1:0] c_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= AW'($unsigned(dd_s2[0])) + AW'($unsigned(dd_s2[1]))
				+ AW'($unsigned(dd_s2[2]));
			h_s3 <= {df_s2[0][PW-1], df_s2[0]} + {df_s2[1][PW-1], df_s2[1]}
				+ {df_s2[2][PW-1], df_s2[2]};
			c_s3 <= {1'b0, ff_s2[0]} + {1'b0, ff_s2[1]} + {1'b0, ff_s2[2]}
				- HW'(rr_s2);
		end
	end

	logic [HW-1:0]   habs;
	logic [HW-1:0]   cabs;
	logic [UDW-1:0]  hh;
	logic [UDW-1:0]  ac;

	assign habs = h_s3[HW-1] ? -h_s3 : h_s3;
	assign cabs = c_s3[HW-1] ? -c_s3 : c_s3;

	ssi_mul #(.WA(MAGW), .WB(MAGW)) u_mul_hh (
		.clk (clk),
		.en  (en),
		.a   (habs[MAGW-1:0]),
		.b   (habs[MAGW-1:0]),
		.p   (hh)
	);

	ssi_mul #(.WA(AW), .WB(MAGW)) u_mul_ac (
		.clk (clk),
		.en  (en),
		.a   (a_s3),
		.b   (cabs[MAGW-1:0]),
		.p   (ac)
	);

	logic [AW+HW:0] ahc_d;

	ssi_dly #(.W(AW+HW+1), .N(L1)) u_dly_ahc (
		.clk (clk),
		.en  (en),
		.d   ({a_s3, h_s3, c_s3[HW-1]}),
		.q   (ahc_d)
	);

	// stage 4: discriminant
	logic [QW-1:0]        disc_s4;
	logic [AW-1:0]        a_s4;
	logic signed [HW-1:0] h_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			disc_s4 <= ahc_d[0] ? {1'b0, hh} + {1'b0, ac} : {1'b0, hh} - {1'b0, ac};
			a_s4    <= ahc_d[AW+HW:HW+1];
			h_s4    <= ahc_d[HW:1];
		end
	end

	logic [RW-1:0]    root;
	logic [AW+HW+1:0] ah_d;

	ssi_sqrt #(.XW(UDW)) u_sqrt (
		.clk  (clk),
		.en   (en),
		.x    (disc_s4[UDW-1:0]),
		.root (root)
	);

	ssi_dly #(.W(AW+HW+2), .N(RW)) u_dly_ah (
		.clk (clk),
		.en  (en),
		.d   ({a_s4, h_s4, disc_s4[QW-1], disc_s4 == '0}),
		.q   (ah_d)
	);

	// stage 5: root numerators
	logic signed [MW-1:0] nh;
	logic signed [MW-1:0] m1;
	logic signed [MW-1:0] m2;
	logic [MW-1:0]        m1abs;
	logic [MW-1:0]        m2abs;
	logic [HW-1:0]        h5;

	assign h5    = ah_d[HW+1:2];
	assign nh    = -{h5[HW-1], h5};
	assign m1    = nh - MW'(root);
	assign m2    = nh + MW'(root);
	assign m1abs = m1[MW-1] ? -m1 : m1;
	assign m2abs = m2[MW-1] ? -m2 : m2;

	logic [MMW-1:0] mmag_s5 [2];
	logic [1:0]     mneg_s5;
	logic [AW-1:0]  a_s5;
	logic           dneg_s5;
	logic           dzero_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			mmag_s5[0] <= m1abs[MMW-1:0];
			mmag_s5[1] <= m2abs[MMW-1:0];
			mneg_s5    <= {m2[MW-1], m1[MW-1]};
			a_s5       <= ah_d[AW+HW+1:HW+2];
			dneg_s5    <= ah_d[1];
			dzero_s5   <= ah_d[0];
		end
	end

	logic [3*CW-1:0] dm_d;

	ssi_dly #(.W(3*CW), .N(N_DM)) u_dly_dm (
		.clk (clk),
		.en  (en),
		.d   (dm_w),
		.q   (dm_d)
	);

	logic [AW-1:0] a_div;

	ssi_dly #(.W(AW), .N(L2)) u_dly_a (
		.clk (clk),
		.en  (en),
		.d   (a_s5),
		.q   (a_div)
	);

	logic [NW-1:0] prod [2][3];
	logic [QB-1:0] mag  [2][3];

	for (genvar j = 0; j < 2; j++) begin : g_root
		for (genvar i = 0; i < 3; i++) begin : g_axis
			ssi_mul #(.WA(CW), .WB(MMW)) u_mul (
				.clk (clk),
				.en  (en),
				.a   (dm_d[i*CW +: CW]),
				.b   (mmag_s5[j]),
				.p   (prod[j][i])
			);

			ssi_div #(.NW(NW), .AW(AW)) u_div (
				.clk (clk),
				.en  (en),
				.n   (prod[j][i]),
				.a   (a_div),
				.mag (mag[j][i])
			);
		end
	end

	logic [3:0]     fl_d;
	logic [SBW-1:0] sb_d;

	ssi_dly #(.W(4), .N(L2+DL)) u_dly_fl (
		.clk (clk),
		.en  (en),
		.d   ({dneg_s5, dzero_s5, mneg_s5}),
		.q   (fl_d)
	);

	ssi_dly #(.W(SBW), .N(N_SB)) u_dly_sb (
		.clk (clk),
		.en  (en),
		.d   (sb_w),
		.q   (sb_d)
	);

	// stage 6: points, saturated
	logic signed [CW-1:0] p_w [2][3];

	always_comb begin
		logic signed [CW-1:0] sv;
		logic signed [SW-1:0] qs;
		logic signed [SW-1:0] v;
		for (int j = 0; j < 2; j++) begin
			for (int i = 0; i < 3; i++) begin
				sv = sb_d[4+i*CW +: CW];
				qs = (sb_d[1+i] ^ fl_d[j]) ? -{{(SW-QB){1'b0}}, mag[j][i]}
					: {{(SW-QB){1'b0}}, mag[j][i]};
				v  = {{(SW-CW){sv[CW-1]}}, sv} + qs;
				if (v > SAT_HI) begin
					p_w[j][i] = SAT_HI[CW-1:0];
				end else if (v < SAT_LO) begin
					p_w[j][i] = SAT_LO[CW-1:0];
				end else begin
					p_w[j][i] = v[CW-1:0];
				end
			end
		end
	end

	logic signed [CW-1:0] p_s6 [2][3];
	logic signed [CW-1:0] s_s6 [3];
	logic signed [CW-1:0] e_s6 [3];
	logic                 degen_s6;
	logic                 dneg_s6;
	logic                 dzero_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s6[0][i] <= p_w[0][i];
				p_s6[1][i] <= p_w[1][i];
				s_s6[i]    <= sb_d[4+i*CW +: CW];
				e_s6[i]    <= sb_d[4+(3+i)*CW +: CW];
			end
			degen_s6 <= sb_d[0];
			dneg_s6  <= fl_d[3];
			dzero_s6 <= fl_d[2];
		end
	end

	// stage 7: box test and slot selection
	logic [1:0]           inb;
	logic                 keep1;
	logic                 keep2;
	logic [1:0]           cnt_w;
	logic signed [CW-1:0] first_w  [3];
	logic signed [CW-1:0] second_w [3];

	always_comb begin
		logic signed [CW-1:0] lo;
		logic signed [CW-1:0] hi;
		inb = 2'b11;
		for (int i = 0; i < 3; i++) begin
			lo = (s_s6[i] < e_s6[i]) ? s_s6[i] : e_s6[i];
			hi = (s_s6[i] < e_s6[i]) ? e_s6[i] : s_s6[i];
			for (int j = 0; j < 2; j++) begin
				if (p_s6[j][i] < lo || p_s6[j][i] > hi) begin
					inb[j] = 1'b0;
				end
			end
		end
		keep1 = !degen_s6 && !dneg_s6 && inb[0];
		keep2 = !degen_s6 && !dneg_s6 && !dzero_s6 && inb[1];
		cnt_w = 2'd0;
		for (int i = 0; i < 3; i++) begin
			first_w[i]  = '0;
			second_w[i] = '0;
		end
		priority if (keep1) begin
			for (int i = 0; i < 3; i++) begin
				first_w[i] = p_s6[0][i];
				if (keep2) begin
					second_w[i] = p_s6[1][i];
				end
			end
			cnt_w = keep2 ? 2'd2 : 2'd1;
		end else if (keep2) begin
			for (int i = 0; i < 3; i++) begin
				first_w[i] = p_s6[1][i];
			end
			cnt_w = 2'd1;
		end else begin
			cnt_w = 2'd0;
		end
	end

	logic [1:0]           cnt_s7;
	logic signed [CW-1:0] first_s7  [3];
	logic signed [CW-1:0] second_s7 [3];
	logic                 degen_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			cnt_s7   <= cnt_w;
			degen_s7 <= degen_s6;
			for (int i = 0; i < 3; i++) begin
				first_s7[i]  <= first_w[i];
				second_s7[i] <= second_w[i];
			end
		end
	end

	assign hit_count  = cnt_s7;
	assign first_x    = first_s7[0];
	assign first_y    = first_s7[1];
	assign first_z    = first_s7[2];
	assign second_x   = second_s7[0];
	assign second_y   = second_s7[1];
	assign second_z   = second_s7[2];
	assign degenerate = degen_s7;

endmodule

[hw/rtl/ssi_dly.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_dly
// Enabled shift line that keeps side data aligned with the arithmetic cells.
// ----------------------------------------------------------------------------
module ssi_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] sr_q [N];

	for (genvar k = 0; k < N; k++) begin : g_tap
		always_ff @(posedge clk) begin
			if (en) begin
				if (k == 0) begin
					sr_q[k] <= d;
				end else begin
					sr_q[k] <= sr_q[(k == 0) ? 0 : k-1];
				end
			end
		end
	end

	assign q = sr_q[N-1];

endmodule

[hw/rtl/ssi_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_mul
// Unsigned multiplier as a row of cells, one multiplier digit per cell.
// ----------------------------------------------------------------------------
module ssi_mul #(
	parameter int WA = 8,
	parameter int WB = 8
) (
	input  logic            clk,
	input  logic            en,
	input  logic [WA-1:0]   a,
	input  logic [WB-1:0]   b,
	output logic [WA+WB-1:0] p
);

	localparam int DIG  = ssi_pkg::MUL_DIG;
	localparam int NSTG = ssi_pkg::mul_lat(WB);
	localparam int WBP  = NSTG * DIG;
	localparam int WP   = WA + WB;
	localparam int PPW  = WA + DIG;

	logic [WA-1:0]  a_q   [NSTG];
	logic [WBP-1:0] b_q   [NSTG];
	logic [WP-1:0]  acc_q [NSTG];

	for (genvar k = 0; k < NSTG; k++) begin : g_cell
		logic [WA-1:0]  a_in;
		logic [WBP-1:0] b_in;
		logic [WP-1:0]  acc_in;
		logic [PPW-1:0] pp;

		if (k == 0) begin : g_first
			assign a_in   = a;
			assign b_in   = WBP'(b);
			assign acc_in = '0;
		end else begin : g_next
			assign a_in   = a_q[k-1];
			assign b_in   = b_q[k-1];
			assign acc_in = acc_q[k-1];
		end

		assign pp = PPW'(a_in) * PPW'(b_in[k*DIG +: DIG]);

		always_ff @(posedge clk) begin
			if (en) begin
				a_q[k]   <= a_in;
				b_q[k]   <= b_in;
				acc_q[k] <= acc_in + (WP'(pp) << (k * DIG));
			end
		end
	end

	assign p = acc_q[NSTG-1];

endmodule

[hw/rtl/ssi_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_sqrt
// Integer square root (floor), one root bit per cell.
// ----------------------------------------------------------------------------
module ssi_sqrt #(
	parameter int XW = 8
) (
	input  logic            clk,
	input  logic            en,
	input  logic [XW-1:0]   x,
	output logic [XW/2-1:0] root
);

	localparam int RW = XW / 2;

	logic [XW-1:0]   x_q    [RW];
	logic [RW-1:0]   root_q [RW];
	logic [RW+1:0]   rem_q  [RW];

	for (genvar k = 0; k < RW; k++) begin : g_cell
		logic [XW-1:0] x_in;
		logic [RW-1:0] root_in;
		logic [RW+1:0] rem_in;
		logic [RW+3:0] t;
		logic [RW+3:0] trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign x_in    = x;
			assign root_in = '0;
			assign rem_in  = '0;
		end else begin : g_next
			assign x_in    = x_q[k-1];
			assign root_in = root_q[k-1];
			assign rem_in  = rem_q[k-1];
		end

		assign t     = {rem_in, x_in[XW-1 -: 2]};
		assign trial = (RW+4)'({root_in, 2'b01});
		assign ge    = t >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				x_q[k]    <= x_in << 2;
				root_q[k] <= {root_in[RW-2:0], ge};
				rem_q[k]  <= (RW+2)'(ge ? t - trial : t);
			end
		end
	end

	assign root = root_q[RW-1];

endmodule

[hw/rtl/ssi_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_div
// Restoring divider row, one quotient bit per cell, with round to nearest
// (ties away from zero) and a clamp of the magnitude.
// ----------------------------------------------------------------------------
module ssi_div #(
	parameter int NW = 8,
	parameter int AW = 8
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [NW-1:0]                  n,
	input  logic [AW-1:0]                  a,
	output logic [ssi_pkg::QUOT_BITS-1:0]  mag
);

	localparam int QB   = ssi_pkg::QUOT_BITS;
	localparam int HIW  = NW + 1;
	localparam int CMPW = HIW + AW;
	localparam logic [QB:0] LIMIT = (QB+1)'(1) << ssi_pkg::CLAMP_EXP;

	logic [NW+QB:0] n_ext;
	logic [HIW-1:0] hi;

	assign n_ext = (NW+QB+1)'(n);
	assign hi    = n_ext[NW+QB:QB];

	logic          ovf0_q;
	logic [AW-1:0] rem0_q;
	logic [QB-1:0] lo0_q;
	logic [AW-1:0] a0_q;

	always_ff @(posedge clk) begin
		if (en) begin
			ovf0_q <= CMPW'(hi) >= CMPW'(a);
			rem0_q <= AW'(hi);
			lo0_q  <= n_ext[QB-1:0];
			a0_q   <= a;
		end
	end

	logic          ovf_q [QB];
	logic [AW-1:0] rem_q [QB];
	logic [QB-1:0] lo_q  [QB];
	logic [QB-1:0] quo_q [QB];
	logic [AW-1:0] a_q   [QB];

	for (genvar j = 0; j < QB; j++) begin : g_cell
		logic          ovf_in;
		logic [AW-1:0] rem_in;
		logic [QB-1:0] lo_in;
		logic [QB-1:0] quo_in;
		logic [AW-1:0] a_in;
		logic [AW:0]   t;
		logic [AW:0]   ae;
		logic          ge;

		if (j == 0) begin : g_first
			assign ovf_in = ovf0_q;
			assign rem_in = rem0_q;
			assign lo_in  = lo0_q;
			assign quo_in = '0;
			assign a_in   = a0_q;
		end else begin : g_next
			assign ovf_in = ovf_q[j-1];
			assign rem_in = rem_q[j-1];
			assign lo_in  = lo_q[j-1];
			assign quo_in = quo_q[j-1];
			assign a_in   = a_q[j-1];
		end

		assign t  = {rem_in, lo_in[QB-1]};
		assign ae = {1'b0, a_in};
		assign ge = t >= ae;

		always_ff @(posedge clk) begin
			if (en) begin
				ovf_q[j] <= ovf_in;
				rem_q[j] <= AW'(ge ? t - ae : t);
				lo_q[j]  <= lo_in << 1;
				quo_q[j] <= {quo_in[QB-2:0], ge};
				a_q[j]   <= a_in;
			end
		end
	end

	logic          rnd;
	logic [QB:0]   sum;
	logic [QB-1:0] mag_q;

	assign rnd = {rem_q[QB-1], 1'b0} >= {1'b0, a_q[QB-1]};
	assign sum = {1'b0, quo_q[QB-1]} + (QB+1)'(rnd);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q <= (ovf_q[QB-1] || sum > LIMIT) ? QB'(LIMIT) : QB'(sum);
		end
	end

	assign mag = mag_q;

endmodule

[bench/tb_segment_sphere_intersection.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_sphere_intersection
// Self-checking bench for the segment / sphere intersection pipeline. A short
// table of directed segments comes first: degenerate, tangent, secant, miss and
// extreme coordinates. Random phases follow, each under its own sphere setting.
// Sphere settings include the largest and smallest centers, a zero and a maximum
// radius. Every beat is checked against its table entry or an exact wide integer
// model of the hit points. Both channels stall at random outside one calm phase.
// ----------------------------------------------------------------------------
module tb_segment_sphere_intersection;

	localparam int ONE   = 1 << ssi_pkg::FRAC_BITS;
	localparam int LIMIT = 400000;
	localparam int DRAIN = 160;
	localparam logic [ssi_pkg::CFG_IDX_W-1:0] REG_UNUSED = 4'd9;
	localparam logic signed [31:0] CMAX = 32'sh7fffffff;
	localparam logic signed [31:0] CMIN = 32'sh80000000;

	typedef logic signed [255:0] wide_t;

	typedef struct packed {
		logic signed [31:0] sx, sy, sz, ex, ey, ez;
	} seg_t;

	typedef struct packed {
		logic [1:0]       cnt;
		logic [5:0][31:0] pt;
		logic             dg;
	} hit_t;

	typedef struct packed {
		seg_t sg;
		bit   typed;
		hit_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ssi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ssi_pkg::COORD_WIDTH-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [ssi_pkg::COORD_WIDTH-1:0] start_x = '0, start_y = '0, start_z = '0;
	logic signed [ssi_pkg::COORD_WIDTH-1:0] end_x = '0, end_y = '0, end_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] hit_count;
	logic signed [ssi_pkg::COORD_WIDTH-1:0] first_x, first_y, first_z;
	logic signed [ssi_pkg::COORD_WIDTH-1:0] second_x, second_y, second_z;
	logic degenerate;

	logic signed [31:0] ctr_x, ctr_y, ctr_z;
	logic [30:0] rad;
	hit_t hits_pending[$];
	row_t rows[$];
	int errors = 0;
	int cycles = 0;
	bit calm = 1'b0;

	segment_sphere_intersection uut (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("segment_sphere_intersection regression: fail");
			$finish;
		end
	end

	always @(posedge clk) out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);

	function automatic wide_t isqrt_wide(wide_t x);
		wide_t r, t;
		r = '0;
		for (int n = 95; n >= 0; n--) begin
			t = r | (wide_t'(1) << n);
			if (t * t <= x) r = t;
		end
		return r;
	endfunction

	// d*m/a rounded half away from zero, clamped to 2**62
	function automatic logic signed [63:0] step_along(wide_t di, wide_t m, wide_t a);
		wide_t n, q, rm, lim;
		bit neg;
		n = di * m;
		neg = n < 0;
		if (neg) n = -n;
		q = n / a;
		rm = n % a;
		if (rm * 2 >= a) q = q + 1;
		lim = wide_t'(1) <<< 62;
		if (q > lim) q = lim;
		return neg ? -q[63:0] : q[63:0];
	endfunction

	function automatic logic [95:0] hit_point(wide_t s[3], wide_t d[3], wide_t m, wide_t a);
		logic signed [63:0] v;
		logic [95:0] p;
		for (int i = 0; i < 3; i++) begin
			v = s[i][63:0] + step_along(d[i], m, a);
			if (v > 64'sh7fffffff) v = 64'sh7fffffff;
			else if (v < -64'sh80000000) v = -64'sh80000000;
			p[i*32 +: 32] = v[31:0];
		end
		return p;
	endfunction

	function automatic bit on_segment(wide_t s[3], wide_t e[3], logic [95:0] p);
		wide_t lo, hi, v;
		for (int i = 0; i < 3; i++) begin
			lo = s[i] < e[i] ? s[i] : e[i];
			hi = s[i] < e[i] ? e[i] : s[i];
			v = $signed(p[i*32 +: 32]);
			if (v < lo || v > hi) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic hit_t intersect_sphere(seg_t sg);
		wide_t s[3], e[3], d[3], f[3], c3[3];
		wide_t a, h, c, rr, disc, rt;
		logic [95:0] p1, p2;
		bit in1, in2;
		hit_t r;
		r = '0;
		s[0] = sg.sx; s[1] = sg.sy; s[2] = sg.sz;
		e[0] = sg.ex; e[1] = sg.ey; e[2] = sg.ez;
		c3[0] = ctr_x; c3[1] = ctr_y; c3[2] = ctr_z;
		rr = {225'b0, rad};
		a = '0; h = '0; c = '0;
		for (int i = 0; i < 3; i++) begin
			d[i] = e[i] - s[i];
			f[i] = s[i] - c3[i];
			a = a + d[i] * d[i];
			h = h + d[i] * f[i];
			c = c + f[i] * f[i];
		end
		if (a == 0) begin
			r.dg = 1'b1;
			return r;
		end
		c = c - rr * rr;
		disc = h * h - a * c;
		if (disc == 0) begin
			p1 = hit_point(s, d, -h, a);
			if (on_segment(s, e, p1)) begin
				r.cnt = 2'd1;
				r.pt[2:0] = p1;
			end
		end else if (disc > 0) begin
			rt = isqrt_wide(disc);
			p1 = hit_point(s, d, -h - rt, a);
			p2 = hit_point(s, d, -h + rt, a);
			in1 = on_segment(s, e, p1);
			in2 = on_segment(s, e, p2);
			if (in1) begin
				r.cnt = 2'd1;
				r.pt[2:0] = p1;
				if (in2) begin
					r.cnt = 2'd2;
					r.pt[5:3] = p2;
				end
			end else if (in2) begin
				r.cnt = 2'd1;
				r.pt[2:0] = p2;
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		hit_t want, got;
		if (out_valid && out_ready) begin
			got.cnt = hit_count;
			got.pt = {second_z, second_y, second_x, first_z, first_y, first_x};
			got.dg = degenerate;
			if (hits_pending.size() == 0) begin
				$display("%0t: unexpected beat, count %0d", $time, got.cnt);
				errors++;
			end else begin
				want = hits_pending.pop_front();
				if (want.cnt !== got.cnt) begin
					$display("%0t: hit_count expected %0d actual %0d", $time, want.cnt,
						got.cnt);
					errors++;
				end
				for (int i = 0; i < 6; i++)
					if (want.pt[i] !== got.pt[i]) begin
						$display("%0t: point %0d expected %0d actual %0d", $time, i,
							$signed(want.pt[i]), $signed(got.pt[i]));
						errors++;
					end
				if (want.dg !== got.dg) begin
					$display("%0t: degenerate expected %0b actual %0b", $time, want.dg,
						got.dg);
					errors++;
				end
			end
		end
	end

	function automatic hit_t mk_hit(logic [1:0] n, int fx, int fy, int fz, int sx, int sy,
		int sz, bit dg);
		hit_t r;
		r.cnt = n;
		r.pt = {sz, sy, sx, fz, fy, fx};
		r.dg = dg;
		return r;
	endfunction

	function automatic seg_t mk_seg(int sx, int sy, int sz, int ex, int ey, int ez);
		seg_t s;
		s = {sx, sy, sz, ex, ey, ez};
		return s;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > longint'(CMAX)) return CMAX;
		if (v < longint'(CMIN)) return CMIN;
		return v[31:0];
	endfunction

	function automatic longint spread(longint span);
		longint u;
		u = longint'({$urandom, $urandom}) & 64'h3fffffffffffffff;
		return (u % (2 * span + 1)) - span;
	endfunction

	function automatic seg_t random_seg();
		seg_t s;
		longint span;
		int kind;
		kind = $urandom_range(99);
		span = rad == 0 ? ONE : 2 * longint'(rad);
		if (kind < 60) begin
			s.sx = clamp32(ctr_x + spread(span));
			s.sy = clamp32(ctr_y + spread(span));
			s.sz = clamp32(ctr_z + spread(span));
			s.ex = clamp32(ctr_x + spread(span));
			s.ey = clamp32(ctr_y + spread(span));
			s.ez = clamp32(ctr_z + spread(span));
		end else if (kind < 80) begin
			s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		end else if (kind < 88) begin
			s.sx = $urandom; s.sy = $urandom; s.sz = $urandom;
			s.ex = s.sx; s.ey = s.sy; s.ez = s.sz;
		end else begin
			// axis-parallel chord, often grazing the sphere
			s.sx = clamp32(ctr_x - span);
			s.ex = clamp32(ctr_x + span);
			s.sy = clamp32(ctr_y + spread(span / 2));
			s.ey = s.sy;
			s.sz = $urandom_range(3) == 0 ? ctr_z : clamp32(ctr_z + spread(span / 2));
			s.ez = s.sz;
		end
		return s;
	endfunction

	task automatic send_seg(seg_t sg, bit typed, hit_t want);
		in_valid <= 1'b1;
		{start_x, start_y, start_z, end_x, end_y, end_z} <= sg;
		do @(posedge clk); while (!in_ready);
		hits_pending.push_back(typed ? want : intersect_sphere(sg));
		if (!calm && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [ssi_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			ssi_pkg::REG_CENTER_X: ctr_x = val;
			ssi_pkg::REG_CENTER_Y: ctr_y = val;
			ssi_pkg::REG_CENTER_Z: ctr_z = val;
			ssi_pkg::REG_RADIUS:   rad = val[30:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain_beats();
		in_valid <= 1'b0;
		@(posedge clk);
		while (hits_pending.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
		logic [31:0] r);
		write_reg(ssi_pkg::REG_CENTER_X, cx);
		write_reg(ssi_pkg::REG_CENTER_Y, cy);
		write_reg(ssi_pkg::REG_CENTER_Z, cz);
		write_reg(ssi_pkg::REG_RADIUS, r);
	endtask

	initial begin
		ctr_x = 0; ctr_y = 0; ctr_z = 0; rad = ONE;
		rows.push_back({mk_seg(0, 0, 0, 0, 0, 0), 1'b1, mk_hit(0, 0, 0, 0, 0, 0, 0, 1)});
		rows.push_back({mk_seg(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), 1'b1,
			mk_hit(0, 0, 0, 0, 0, 0, 0, 1)});
		rows.push_back({mk_seg(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN), 1'b1,
			mk_hit(0, 0, 0, 0, 0, 0, 0, 1)});
		rows.push_back({mk_seg(-2*ONE, 0, 0, 2*ONE, 0, 0), 1'b1,
			mk_hit(2, -ONE, 0, 0, ONE, 0, 0, 0)});
		rows.push_back({mk_seg(-2*ONE, ONE, 0, 2*ONE, ONE, 0), 1'b1,
			mk_hit(1, 0, ONE, 0, 0, 0, 0, 0)});
		rows.push_back({mk_seg(-2*ONE, 3*ONE, 0, 2*ONE, 3*ONE, 0), 1'b1,
			mk_hit(0, 0, 0, 0, 0, 0, 0, 0)});
		rows.push_back({mk_seg(-ONE/2, 0, 0, ONE/2, 0, 0), 1'b1,
			mk_hit(0, 0, 0, 0, 0, 0, 0, 0)});
		rows.push_back({mk_seg(0, 0, 0, 2*ONE, 0, 0), 1'b1,
			mk_hit(1, ONE, 0, 0, 0, 0, 0, 0)});
		rows.push_back({mk_seg(2*ONE, 0, 0, -2*ONE, 0, 0), 1'b0, hit_t'(0)});
		rows.push_back({mk_seg(0, -2*ONE, 0, 0, 2*ONE, 0), 1'b0, hit_t'(0)});
		rows.push_back({mk_seg(0, 0, 2*ONE, 0, 0, -2*ONE), 1'b0, hit_t'(0)});
		rows.push_back({mk_seg(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX), 1'b0, hit_t'(0)});
		rows.push_back({mk_seg(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN), 1'b0, hit_t'(0)});
		rows.push_back({mk_seg(CMIN, 0, 0, CMAX, 0, 0), 1'b0, hit_t'(0)});
		rows.push_back({mk_seg(0, CMAX, 0, 0, CMIN, 0), 1'b0, hit_t'(0)});
		rows.push_back({mk_seg(-3*ONE, -ONE, -ONE/3, 3*ONE, ONE, ONE/3), 1'b0, hit_t'(0)});
		rows.push_back({mk_seg(ONE, ONE, 0, 0, 0, 0), 1'b0, hit_t'(0)});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[k]) send_seg(rows[k].sg, rows[k].typed, rows[k].want);
		drain_beats();

		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: set_sphere(0, 0, 0, 32'h7fffffff);
				1: set_sphere(CMIN, CMIN, CMIN, 0);
				2: set_sphere(CMAX, CMAX, CMAX, 10 * ONE);
				3: begin
					set_sphere(-5 * ONE, 7 * ONE, ONE / 3, 3);
					write_reg(REG_UNUSED, $urandom);
				end
				default: set_sphere($urandom, $urandom, $urandom, $urandom_range(0, 1 << 24));
			endcase
			calm = (ph == 4);
			for (int k = 0; k < 162; k++) send_seg(random_seg(), 1'b0, hit_t'(0));
			drain_beats();
			calm = 1'b0;
		end

		if (errors == 0)
			$display("segment_sphere_intersection regression: pass");
		else
			$display("segment_sphere_intersection regression: fail");
		$finish;
	end

endmodule

[segment_sphere_intersection.f]
hw/rtl/ssi_pkg.sv
hw/rtl/ssi_dly.sv
hw/rtl/ssi_mul.sv
hw/rtl/ssi_sqrt.sv
hw/rtl/ssi_div.sv
hw/rtl/segment_sphere_intersection.sv
bench/tb_segment_sphere_intersection.sv
